// ===== rtl/laf_pkg.sv =====
package laf_pkg;

    localparam int DEF_TAPS = 16;
    localparam int SMP_W    = 16;
    localparam int W_W      = 24;
    localparam int STEP_W   = 16;
    localparam int ME_W     = 34;
    localparam int PROD_W   = ME_W + SMP_W;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;

    typedef enum logic [2:0] {
        C_HOLD,
        C_SHIFT,
        C_SHIFT_CLR,
        C_ROTATE,
        C_CLEAR
    } t_cell_op;

    typedef struct packed {
        logic step;
        logic load_real;
        logic upd;
        logic acc_clr;
        logic acc_en;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_FIN,
        S_ME,
        S_UPD,
        S_CLR
    } t_state;

endpackage

// ===== rtl/laf_if.sv =====
interface laf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic [15:0] desired_sample;
    logic        last_of_run;
    modport source (output valid, sample, desired_sample, last_of_run, input ready);
    modport sink (input valid, sample, desired_sample, last_of_run, output ready);
endinterface

interface laf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] filtered;
    logic [15:0] error_value;
    modport source (output valid, filtered, error_value, input ready);
    modport sink (input valid, filtered, error_value, output ready);
endinterface

interface laf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] step_size;
    modport source (output valid, step_size, input ready);
    modport sink (input valid, step_size, output ready);
endinterface

// ===== rtl/laf_cell.sv =====
module laf_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  laf_pkg::t_cell_op i_op,
    input  logic [15:0]       i_left_x,
    input  logic [15:0]       i_right_x,
    input  logic [23:0]       i_right_w,
    output logic [15:0]       o_x,
    output logic [23:0]       o_w
);
    import laf_pkg::*;

    logic [SMP_W-1:0] r_x;
    logic [W_W-1:0]   r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_w <= '0;
        end else begin
            unique case (i_op)
                C_HOLD: ;
                C_SHIFT: r_x <= i_left_x;
                C_SHIFT_CLR: begin
                    r_x <= i_left_x;
                    r_w <= '0;
                end
                C_ROTATE: begin
                    r_x <= i_right_x;
                    r_w <= i_right_w;
                end
                C_CLEAR: r_w <= '0;
                default: ;
            endcase
        end
    end

    assign o_x = r_x;
    assign o_w = r_w;
endmodule

// ===== rtl/laf_mac.sv =====
module laf_mac #(
    parameter int ACC_W = 45
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  laf_pkg::t_mac_ctl i_ctl,
    input  logic [15:0]       i_head_x,
    input  logic [23:0]       i_head_w,
    input  logic [33:0]       i_me,
    output logic [15:0]       o_tail_x,
    output logic [23:0]       o_tail_w,
    output logic [ACC_W-1:0]  o_acc
);
    import laf_pkg::*;

    logic              r_sv;
    logic [SMP_W-1:0]  r_sx;
    logic [W_W-1:0]    r_sw;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;

    logic signed [ME_W-1:0]   opa;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] nw;

    always_comb begin
        opa  = i_ctl.upd ? $signed(i_me) : ME_W'($signed(i_head_w));
        prod = PROD_W'(opa) * PROD_W'($signed(i_head_x));
    end

    // delta rounded to Q4.20, then saturating add
    always_comb begin
        rnd = ($signed(r_prod) + (PROD_W'(1) <<< 25)) >>> 26;
        nw  = PROD_W'($signed(r_sw)) + rnd;
        if (nw > PROD_W'(8388607))
            o_tail_w = 24'h7fffff;
        else if (nw < -PROD_W'(8388608))
            o_tail_w = 24'h800000;
        else
            o_tail_w = nw[W_W-1:0];
        if (!i_ctl.upd)
            o_tail_w = r_sw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (i_ctl.step) begin
            r_sv <= i_ctl.load_real;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_sx   <= i_head_x;
            r_sw   <= i_head_w;
            r_prod <= prod;
        end
        if (i_ctl.acc_clr)
            r_acc <= '0;
        else if (i_ctl.acc_en && r_sv)
            r_acc <= r_acc + r_prod[ACC_W-1:0];
    end

    assign o_tail_x = r_sx;
    assign o_acc    = r_acc;
endmodule

// ===== rtl/lms_adaptive_fir_unit.sv =====
// A warm input transfer starts the MAC pass (S_MAC); S_FIN then registers the result and raises
// valid, and S_ME and S_UPD update the weights. A new input is taken only in S_IDLE, after the
// update (and S_CLR with last_of_run); S_FIN waits while the previous result waits for transfer,
// and warm-up items are only shifted in. One shared multiplier sits at the head of a rotating ring
// of tap cells, used once around for the MAC pass and once for the weight update.
// Reset: synchronous, active low; taps, weights and warm-up count cleared, step_size = 328.
module lms_adaptive_fir_unit #(
    parameter int TAPS = laf_pkg::DEF_TAPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    laf_in_if.sink      i_smp,
    laf_cfg_if.sink     i_cfg,
    laf_out_if.source   o_res
);
    import laf_pkg::*;

    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int ACC_W = 40 + $clog2(TAPS) + 1;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_wcnt;
    logic                 r_last;
    logic [SMP_W-1:0]     r_d;
    logic [SMP_W-1:0]     r_y, r_e;
    logic                 r_ov;
    logic [ME_W-1:0]      r_me;
    logic [STEP_W-1:0]    r_step;

    t_cell_op             cell_op;
    t_mac_ctl             mac_ctl;
    logic                 in_xfer, warm, cnt_end, fin_go;

    logic [SMP_W-1:0]     cx [TAPS];
    logic [W_W-1:0]       cw [TAPS];
    logic [SMP_W-1:0]     tail_x;
    logic [W_W-1:0]       tail_w;
    logic [ACC_W-1:0]     acc;

    logic signed [ACC_W-1:0] acc_r;
    logic [SMP_W-1:0]        y_sat, e_sat;
    logic signed [SMP_W:0]   diff;

    assign warm    = (r_wcnt == CNT_W'(TAPS));
    assign in_xfer = i_smp.valid && i_smp.ready;
    assign cnt_end = (r_cnt == CNT_W'(TAPS));
    assign fin_go  = !r_ov || o_res.ready;

    assign i_smp.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer && warm) n_state = S_MAC;
            S_MAC:  if (cnt_end) n_state = S_FIN;
            S_FIN:  if (fin_go) n_state = S_ME;
            S_ME:   n_state = S_UPD;
            S_UPD:  if (cnt_end) n_state = r_last ? S_CLR : S_IDLE;
            S_CLR:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cell_op = C_HOLD;
        mac_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer)
                    cell_op = (i_smp.last_of_run && !warm) ? C_SHIFT_CLR : C_SHIFT;
                mac_ctl.acc_clr = 1'b1;
            end
            S_MAC: begin
                cell_op           = C_ROTATE;
                mac_ctl.step      = 1'b1;
                mac_ctl.load_real = !cnt_end;
                mac_ctl.acc_en    = 1'b1;
            end
            S_UPD: begin
                cell_op           = C_ROTATE;
                mac_ctl.step      = 1'b1;
                mac_ctl.load_real = !cnt_end;
                mac_ctl.upd       = 1'b1;
            end
            S_CLR: cell_op = C_CLEAR;
            S_FIN, S_ME: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wcnt  <= '0;
            r_ov    <= 1'b0;
            r_step  <= STEP_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid)
                r_step <= i_cfg.step_size;
            if (r_state == S_MAC || r_state == S_UPD)
                r_cnt <= cnt_end ? '0 : r_cnt + 1'b1;
            else
                r_cnt <= '0;
            if (in_xfer) begin
                if (i_smp.last_of_run)
                    r_wcnt <= '0;
                else if (!warm)
                    r_wcnt <= r_wcnt + 1'b1;
            end
            if (r_state == S_FIN && fin_go)
                r_ov <= 1'b1;
            else if (o_res.ready)
                r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_d    <= i_smp.desired_sample;
            r_last <= i_smp.last_of_run;
        end
        if (r_state == S_FIN && fin_go) begin
            r_y <= y_sat;
            r_e <= e_sat;
        end
        if (r_state == S_ME)
            r_me <= ME_W'($signed({1'b0, r_step, 1'b0})) * ME_W'($signed(r_e));
    end

    // y: round to Q1.15 and saturate, e = d - y saturated
    always_comb begin
        acc_r = ($signed(acc) + (ACC_W'(1) <<< 19)) >>> 20;
        if (acc_r > $signed(ACC_W'(32767)))
            y_sat = 16'h7fff;
        else if (acc_r < -$signed(ACC_W'(32768)))
            y_sat = 16'h8000;
        else
            y_sat = acc_r[SMP_W-1:0];
        diff = $signed({r_d[SMP_W-1], r_d}) - $signed({y_sat[SMP_W-1], y_sat});
        if (diff[SMP_W] != diff[SMP_W-1])
            e_sat = diff[SMP_W] ? 16'h8000 : 16'h7fff;
        else
            e_sat = diff[SMP_W-1:0];
    end

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        laf_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (cell_op),
            .i_left_x  ((k == 0) ? i_smp.sample : cx[(k == 0) ? 0 : k - 1]),
            .i_right_x ((k == TAPS - 1) ? tail_x : cx[(k == TAPS - 1) ? k : k + 1]),
            .i_right_w ((k == TAPS - 1) ? tail_w : cw[(k == TAPS - 1) ? k : k + 1]),
            .o_x       (cx[k]),
            .o_w       (cw[k])
        );
    end

    laf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_head_x (cx[0]),
        .i_head_w (cw[0]),
        .i_me     (r_me),
        .o_tail_x (tail_x),
        .o_tail_w (tail_w),
        .o_acc    (acc)
    );

    assign o_res.valid       = r_ov;
    assign o_res.filtered    = r_y;
    assign o_res.error_value = r_e;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC || r_state == S_UPD) |-> (r_cnt <= CNT_W'(TAPS)))
        else $error("ring counter out of range");
    a_mac_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && in_xfer && n_state == S_MAC) |-> warm)
        else $error("MAC pass started during warm-up");
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && fin_go) |=> (r_ov && r_state == S_ME))
        else $error("result not registered on leaving FIN");
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_smp.ready)
        else $error("input ready while busy");
`endif
endmodule

// ===== tb/lms_adaptive_fir_unit_tb.sv =====
module lms_adaptive_fir_unit_tb;
    import laf_pkg::*;

    localparam int NTAPS = DEF_TAPS;

    typedef struct packed {
        logic [15:0] filtered;
        logic [15:0] error_value;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    laf_in_if  smp_if ();
    laf_cfg_if cfg_if ();
    laf_out_if res_if ();

    lms_adaptive_fir_unit #(.TAPS(NTAPS)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_if.sink),
        .i_cfg  (cfg_if.sink),
        .o_res  (res_if.source)
    );

    // predictor state
    logic signed [15:0] line_q[NTAPS];
    logic signed [23:0] wt_q[NTAPS];
    int unsigned        seen_cnt;
    logic [15:0]        mu_q;

    t_result expected_q[$];
    int      fail_cnt;
    int      sent_cnt;
    int      got_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("status: fail");
        $finish;
    end

    function automatic longint rnd_shift(longint a, int s);
        return (a + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic predict_lms(logic [15:0] x, logic [15:0] d, logic last);
        longint acc;
        longint y;
        longint e;
        longint p;
        t_result r;
        logic warm;
        warm = seen_cnt >= NTAPS;
        for (int j = NTAPS - 1; j > 0; j--) line_q[j] = line_q[j-1];
        line_q[0] = x;
        if (warm) begin
            acc = 0;
            for (int j = 0; j < NTAPS; j++) acc += longint'(wt_q[j]) * longint'(line_q[j]);
            y = clip(rnd_shift(acc, 20), -32768, 32767);
            e = clip(longint'($signed(d)) - y, -32768, 32767);
            for (int j = 0; j < NTAPS; j++) begin
                p = 2 * longint'(mu_q) * e * longint'(line_q[j]);
                wt_q[j] = 24'(clip(longint'(wt_q[j]) + rnd_shift(p, 26), -8388608, 8388607));
            end
            r.filtered = y[15:0];
            r.error_value = e[15:0];
            expected_q.push_back(r);
        end
        if (seen_cnt < NTAPS) seen_cnt++;
        if (last) begin
            for (int j = 0; j < NTAPS; j++) wt_q[j] = '0;
            seen_cnt = 0;
        end
    endtask

    task automatic send_sample(logic [15:0] x, logic [15:0] d, logic last);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.sample <= x;
        smp_if.desired_sample <= d;
        smp_if.last_of_run <= last;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        predict_lms(x, d, last);
        sent_cnt++;
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        smp_if.valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_step(logic [15:0] v);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.step_size <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        mu_q = v;
    endtask

    function automatic logic [15:0] rnd_smp();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 2047)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        for (int i = 0; i < 20; i++) begin
            send_sample((i % 2) ? 16'h7fff : 16'h8000, (i % 3) ? 16'h7fff : 16'h8000, 1'b0);
        end
        send_sample(16'h0000, 16'h0000, 1'b0);
        send_sample(16'hffff, 16'h0001, 1'b1);
        send_sample(16'h1234, 16'h4321, 1'b0);
    endtask

    task automatic test_step_sizes();
        logic [15:0] steps[4] = '{16'hffff, 16'h0000, 16'h0001, 16'd328};
        foreach (steps[k]) begin
            write_step(steps[k]);
            for (int i = 0; i < 40; i++) send_sample(rnd_smp(), rnd_smp(), i == 39);
        end
    endtask

    task automatic test_random_runs();
        int run_len;
        int n;
        n = 0;
        while (n < 550) begin
            if ($urandom_range(0, 5) == 0) write_step(16'($urandom));
            run_len = $urandom_range(1, 60);
            for (int i = 0; i < run_len; i++) begin
                send_sample(rnd_smp(), rnd_smp(),
                            (i == run_len - 1) && ($urandom_range(0, 2) == 0));
                n++;
            end
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_cnt++;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result filtered=%h error=%h", $time,
                         res_if.filtered, res_if.error_value);
                fail_cnt++;
            end else begin
                exp_r = expected_q.pop_front();
                if (res_if.filtered !== exp_r.filtered) begin
                    $display("%0t filtered exp=%h act=%h", $time, exp_r.filtered,
                             res_if.filtered);
                    fail_cnt++;
                end
                if (res_if.error_value !== exp_r.error_value) begin
                    $display("%0t error_value exp=%h act=%h", $time, exp_r.error_value,
                             res_if.error_value);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int hold;
        res_if.ready = 1'b0;
        forever begin
            hold = $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold != 0) begin
                res_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    initial begin
        fail_cnt = 0;
        sent_cnt = 0;
        got_cnt = 0;
        seen_cnt = 0;
        mu_q = STEP_RESET;
        for (int j = 0; j < NTAPS; j++) begin
            line_q[j] = '0;
            wt_q[j] = '0;
        end
        i_rst_n = 1'b0;
        smp_if.valid = 1'b0;
        smp_if.sample = '0;
        smp_if.desired_sample = '0;
        smp_if.last_of_run = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.step_size = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_step_sizes();
        test_random_runs();
        drain_results();

        if (expected_q.size() != 0) begin
            $display("%0t %0d expected results never arrived", $time, expected_q.size());
            fail_cnt++;
        end
        $display("covered %0d samples, %0d filter outputs checked, step sizes 0 to 65535",
                 sent_cnt, got_cnt);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/laf_pkg.sv
rtl/laf_if.sv
rtl/laf_cell.sv
rtl/laf_mac.sv
rtl/lms_adaptive_fir_unit.sv
tb/lms_adaptive_fir_unit_tb.sv
